>>> hw/rtl/chm_pkg.sv
package chm_pkg;

	// map geometry
	localparam int BUCKETS = 64;
	localparam int ENTRIES = 256;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int ENT_AW  = $clog2(ENTRIES);
	localparam int IDX_W   = ENT_AW + 1;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(ENTRIES);

	// command codes
	localparam logic [2:0] CMD_GET    = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_SET    = 3'd2;
	localparam logic [2:0] CMD_REMOVE = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// register index
	localparam logic REG_KEY_MODE = 1'b0;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic [8:0]       entry_count;
	} rsp_t;

	// controller -> datapath commands
	typedef struct packed {
		logic accept;
		logic load;
		logic chk;
		logic cmp;
		logic act;
		logic alloc;
		logic ins1;
		logic ins2;
		logic rm1;
		logic rm2;
		logic clr;
		logic fin;
	} ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic [2:0] in_cmd;
		logic [2:0] cmd;
		logic       ptr_nil;
		logic       key_eq;
		logic       hit;
		logic       full;
		logic       out_busy;
	} sts_t;

	// key mode 0: xor-shift mix, logical shifts on the 32-bit key; key mode 1 takes the low key bits as they are
	function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] k,
			input logic mode);
		logic [KEY_W-1:0] h;
		begin
			h = k;
			if (!mode) begin
				h = h ^ (h >> 20) ^ (h >> 12);
				h = h ^ (h >> 7) ^ (h >> 4);
			end
			return h[BKT_W-1:0];
		end
	endfunction

endpackage

>>> hw/rtl/chained_hash_map_engine.sv
// Chained hash map: 256-entry key/value pool, 64 buckets, doubly linked chains.
// Each command item returns one result item, and a new item is taken only while the
// engine is idle. An item reads its bucket head, loads it, walks the chain (one
// memory read and one key compare per entry passed over) up to the match or the
// end, then writes, inserts or removes where needed and loads the result register;
// clear and unused codes go straight to the result. Loading the result waits while
// the previous result item is stalled. The walk runs through the single-port entry
// memories. Clear needs no walk: bucket heads carry valid bits and the free list is
// rebuilt by a fill mark. Write key_mode only while idle.
module chained_hash_map_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  chm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output chm_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	chm_pkg::ctl_t ctl;
	chm_pkg::sts_t sts;
	logic          key_mode_q;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			key_mode_q <= 1'b0;
		else if (psel && penable && pwrite && paddr[2] == chm_pkg::REG_KEY_MODE)
			key_mode_q <= pwdata[0];
	end
	assign prdata = (paddr[2] == chm_pkg::REG_KEY_MODE) ? {31'd0, key_mode_q} : 32'd0;

	chm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	chm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_mode  (key_mode_q),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

>>> hw/rtl/chm_ctrl.sv
module chm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  chm_pkg::sts_t  sts,
	output chm_pkg::ctl_t  ctl
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_HEAD  = 12'b000000000010,
		S_LOAD  = 12'b000000000100,
		S_CHK   = 12'b000000001000,
		S_CMP   = 12'b000000010000,
		S_ACT   = 12'b000000100000,
		S_ALLOC = 12'b000001000000,
		S_INS1  = 12'b000010000000,
		S_INS2  = 12'b000100000000,
		S_RM1   = 12'b001000000000,
		S_RM2   = 12'b010000000000,
		S_FIN   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	// command decode
	always_comb begin
		ctl        = '0;
		ctl.accept = (state_q == S_IDLE) && req_valid;
		ctl.load   = (state_q == S_LOAD);
		ctl.chk    = (state_q == S_CHK);
		ctl.cmp    = (state_q == S_CMP);
		ctl.act    = (state_q == S_ACT);
		ctl.alloc  = (state_q == S_ALLOC);
		ctl.ins1   = (state_q == S_INS1);
		ctl.ins2   = (state_q == S_INS2);
		ctl.rm1    = (state_q == S_RM1);
		ctl.rm2    = (state_q == S_RM2);
		// clear lands on the accepting edge, so the result sees the empty map
		ctl.clr    = (state_q == S_IDLE) && req_valid && (sts.in_cmd == chm_pkg::CMD_CLEAR);
		ctl.fin    = (state_q == S_FIN) && !sts.out_busy;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (sts.in_cmd inside {chm_pkg::CMD_GET, chm_pkg::CMD_ADD,
							chm_pkg::CMD_SET, chm_pkg::CMD_REMOVE})
						state_d = S_HEAD;
					else
						state_d = S_FIN;
				end
			end
			S_HEAD: state_d = S_LOAD;
			S_LOAD: state_d = S_CHK;
			S_CHK:  state_d = sts.ptr_nil ? S_ACT : S_CMP;
			S_CMP:  state_d = sts.key_eq ? S_ACT : S_CHK;
			S_ACT: begin
				state_d = S_FIN;
				if (sts.cmd == chm_pkg::CMD_REMOVE && sts.hit)
					state_d = S_RM1;
				else if ((sts.cmd == chm_pkg::CMD_ADD || sts.cmd == chm_pkg::CMD_SET)
						&& !sts.hit && !sts.full)
					state_d = S_ALLOC;
			end
			S_ALLOC: state_d = S_INS1;
			S_INS1:  state_d = S_INS2;
			S_INS2:  state_d = S_FIN;
			S_RM1:   state_d = S_RM2;
			S_RM2:   state_d = S_FIN;
			S_FIN:   if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/chm_dp.sv
module chm_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           key_mode,
	input  chm_pkg::req_t  req,
	output chm_pkg::rsp_t  rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  chm_pkg::ctl_t  ctl,
	output chm_pkg::sts_t  sts
);

	localparam int IW = chm_pkg::IDX_W;
	localparam int AW = chm_pkg::ENT_AW;
	localparam int BW = chm_pkg::BKT_W;

	// memories
	logic [IW-1:0]               bhead_mem [chm_pkg::BUCKETS];
	logic [chm_pkg::BUCKETS-1:0] bvalid_q;
	logic [chm_pkg::KEY_W-1:0]   key_mem   [chm_pkg::ENTRIES];
	logic [chm_pkg::VAL_W-1:0]   val_mem   [chm_pkg::ENTRIES];
	logic [IW-1:0]               next_mem  [chm_pkg::ENTRIES];
	logic [IW-1:0]               prev_mem  [chm_pkg::ENTRIES];

	logic [IW-1:0]             bhead_rd, next_rd, prev_rd;
	logic [chm_pkg::KEY_W-1:0] key_rd;
	logic [chm_pkg::VAL_W-1:0] val_rd;

	// item and walk registers
	logic [2:0]                cmd_q;
	logic [chm_pkg::KEY_W-1:0] key_q;
	logic [chm_pkg::VAL_W-1:0] val_q;
	logic [chm_pkg::VAL_W-1:0] rdval_q;
	logic [BW-1:0]             bkt_q;
	logic [IW-1:0]             p_q, head_q, nx_q, pv_q, ins_q;
	logic                      hit_q, full_q;

	// allocator state
	logic [IW-1:0] free_head_q, fresh_q, used_q;

	logic [AW-1:0] rd_addr;
	logic          rsp_valid_q;
	chm_pkg::rsp_t rsp_q;
	logic [1:0]    status_d;

	assign rd_addr = ctl.alloc ? free_head_q[AW-1:0] : p_q[AW-1:0];

	// registered reads
	always_ff @(posedge clk) begin
		bhead_rd <= bhead_mem[bkt_q];
		key_rd   <= key_mem[rd_addr];
		val_rd   <= val_mem[rd_addr];
		next_rd  <= next_mem[rd_addr];
		prev_rd  <= prev_mem[rd_addr];
	end

	// memory writes, one per memory per cycle
	always_ff @(posedge clk) begin
		if (ctl.ins1) begin
			key_mem[free_head_q[AW-1:0]]  <= key_q;
			val_mem[free_head_q[AW-1:0]]  <= val_q;
			next_mem[free_head_q[AW-1:0]] <= head_q;
			prev_mem[free_head_q[AW-1:0]] <= chm_pkg::NIL_IDX;
			bhead_mem[bkt_q]              <= free_head_q;
		end
		if (ctl.act && cmd_q == chm_pkg::CMD_SET && hit_q)
			val_mem[p_q[AW-1:0]] <= val_q;
		if (ctl.ins2 && head_q != chm_pkg::NIL_IDX)
			prev_mem[head_q[AW-1:0]] <= ins_q;
		if (ctl.rm1) begin
			next_mem[p_q[AW-1:0]] <= free_head_q;
			if (head_q == p_q)
				bhead_mem[bkt_q] <= nx_q;
			if (nx_q != chm_pkg::NIL_IDX)
				prev_mem[nx_q[AW-1:0]] <= pv_q;
		end
		if (ctl.rm2 && pv_q != chm_pkg::NIL_IDX)
			next_mem[pv_q[AW-1:0]] <= nx_q;
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= req.cmd;
			key_q   <= req.key;
			val_q   <= req.value;
			bkt_q   <= chm_pkg::bucket_of(req.key, key_mode);
			hit_q   <= 1'b0;
			rdval_q <= '0;
		end
		if (ctl.load) begin
			p_q    <= bvalid_q[bkt_q] ? bhead_rd : chm_pkg::NIL_IDX;
			head_q <= bvalid_q[bkt_q] ? bhead_rd : chm_pkg::NIL_IDX;
		end
		if (ctl.cmp) begin
			if (key_rd == key_q) begin
				hit_q   <= 1'b1;
				nx_q    <= next_rd;
				pv_q    <= prev_rd;
				rdval_q <= val_rd;
			end else begin
				p_q <= next_rd;
			end
		end
		if (ctl.act)
			full_q <= (used_q == chm_pkg::NIL_IDX);
		if (ctl.ins1)
			ins_q <= free_head_q;
	end

	// bucket valid bits, free list and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q    <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			used_q      <= '0;
		end else if (ctl.clr) begin
			bvalid_q    <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			used_q      <= '0;
		end else if (ctl.ins1) begin
			bvalid_q[bkt_q] <= 1'b1;
			used_q          <= used_q + 1'b1;
			// entries at or past the fill mark are still in reset order
			if (free_head_q >= fresh_q) begin
				free_head_q <= free_head_q + 1'b1;
				fresh_q     <= free_head_q + 1'b1;
			end else begin
				free_head_q <= next_rd;
			end
		end else if (ctl.rm1) begin
			free_head_q <= p_q;
			used_q      <= used_q - 1'b1;
		end
	end

	// result status
	always_comb begin
		status_d = chm_pkg::ST_DONE;
		case (cmd_q)
			chm_pkg::CMD_GET, chm_pkg::CMD_REMOVE:
				if (!hit_q) status_d = chm_pkg::ST_MISS;
			chm_pkg::CMD_ADD:
				if (hit_q) status_d = chm_pkg::ST_MISS;
				else if (full_q) status_d = chm_pkg::ST_FULL;
			chm_pkg::CMD_SET:
				if (!hit_q && full_q) status_d = chm_pkg::ST_FULL;
			default: status_d = chm_pkg::ST_DONE;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			rsp_q.status      <= status_d;
			rsp_q.hit         <= hit_q;
			rsp_q.read_value  <= (cmd_q == chm_pkg::CMD_GET) ? rdval_q : '0;
			rsp_q.entry_count <= used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (ctl.fin)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.in_cmd   = req.cmd;
		sts.cmd      = cmd_q;
		sts.ptr_nil  = (p_q == chm_pkg::NIL_IDX);
		sts.key_eq   = (key_rd == key_q);
		sts.hit      = hit_q;
		sts.full     = (used_q == chm_pkg::NIL_IDX);
		sts.out_busy = rsp_valid_q && rsp_stall;
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= chm_pkg::NIL_IDX) else $error("entry count beyond pool size");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins1 |-> used_q < chm_pkg::NIL_IDX) else $error("insert into full pool");
	a_rm_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rm1 |-> used_q != '0 && hit_q) else $error("remove without entry");

endmodule

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int N_RANDOM    = 1000;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	chm_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	chm_pkg::rsp_t rsp;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [2:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	chained_hash_map_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the map: chains in a pool, same layout and order as the block
	logic        mode_q;
	logic [8:0]  head_q [chm_pkg::BUCKETS];
	logic [31:0] key_q  [chm_pkg::ENTRIES];
	logic [31:0] val_q  [chm_pkg::ENTRIES];
	logic [8:0]  next_q [chm_pkg::ENTRIES];
	logic [8:0]  prev_q [chm_pkg::ENTRIES];
	logic [8:0]  free_q;
	logic [8:0]  count_q;

	chm_pkg::rsp_t pending_rsp [$];
	int   errors;
	int   sent;
	int   idle_cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic watchdog_on;

	// directed rows: req plus optional typed-in expectation
	typedef struct {
		chm_pkg::req_t r;
		bit            fixed;
		chm_pkg::rsp_t e;
	} row_t;

	// live keys, to aim random traffic at hits
	logic [31:0] live_keys [$];

	function automatic void map_empty();
		for (int i = 0; i < chm_pkg::BUCKETS; i++) head_q[i] = chm_pkg::NIL_IDX;
		for (int i = 0; i < chm_pkg::ENTRIES; i++) next_q[i] = 9'(i + 1);
		free_q  = '0;
		count_q = '0;
	endfunction

	function automatic logic [5:0] hash_bucket(input logic [31:0] k);
		logic [31:0] h;
		h = k;
		if (!mode_q) begin
			h = h ^ (h >> 20) ^ (h >> 12);
			h = h ^ (h >> 7) ^ (h >> 4);
		end
		return h[5:0];
	endfunction

	// apply one command to the shadow map and return the result it gives
	function automatic chm_pkg::rsp_t map_apply(input chm_pkg::req_t r);
		chm_pkg::rsp_t o;
		logic [5:0]    b;
		logic [8:0]    p;
		logic [8:0]    e;
		logic [8:0]    nx;
		logic [8:0]    pv;
		int            steps;
		o = '0;
		b = hash_bucket(r.key);
		p = chm_pkg::NIL_IDX;
		if (r.cmd <= chm_pkg::CMD_REMOVE) begin
			p = head_q[b];
			steps = 0;
			while (p < chm_pkg::NIL_IDX && steps < chm_pkg::ENTRIES
					&& key_q[p[7:0]] != r.key) begin
				p = next_q[p[7:0]];
				steps++;
			end
			if (steps >= chm_pkg::ENTRIES) p = chm_pkg::NIL_IDX;
			o.hit = p < chm_pkg::NIL_IDX;
		end
		case (r.cmd)
			chm_pkg::CMD_GET: begin
				if (o.hit) o.read_value = val_q[p[7:0]];
				else o.status = chm_pkg::ST_MISS;
			end
			chm_pkg::CMD_ADD, chm_pkg::CMD_SET: begin
				if (o.hit) begin
					if (r.cmd == chm_pkg::CMD_ADD) o.status = chm_pkg::ST_MISS;
					else val_q[p[7:0]] = r.value;
				end else if (count_q >= chm_pkg::ENTRIES || free_q >= chm_pkg::NIL_IDX) begin
					o.status = chm_pkg::ST_FULL;
				end else begin
					e = free_q;
					free_q = next_q[e[7:0]];
					key_q[e[7:0]]  = r.key;
					val_q[e[7:0]]  = r.value;
					next_q[e[7:0]] = head_q[b];
					prev_q[e[7:0]] = chm_pkg::NIL_IDX;
					if (head_q[b] < chm_pkg::NIL_IDX) prev_q[head_q[b][7:0]] = e;
					head_q[b] = e;
					count_q++;
				end
			end
			chm_pkg::CMD_REMOVE: begin
				if (o.hit) begin
					nx = next_q[p[7:0]];
					pv = prev_q[p[7:0]];
					if (head_q[b] == p) head_q[b] = nx;
					if (pv < chm_pkg::NIL_IDX) next_q[pv[7:0]] = nx;
					if (nx < chm_pkg::NIL_IDX) prev_q[nx[7:0]] = pv;
					next_q[p[7:0]] = free_q;
					free_q = p;
					if (count_q > 0) count_q--;
				end else begin
					o.status = chm_pkg::ST_MISS;
				end
			end
			chm_pkg::CMD_CLEAR: map_empty();
			default: ;
		endcase
		o.entry_count = count_q;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random stall, check each accepted result
	always @(negedge clk) begin
		if (recv_stall_pct > 0) rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		else rsp_stall <= 1'b0;
	end

	always @(posedge clk) begin
		chm_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result", 32'(rsp.status), 32'hffffffff);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.hit !== want.hit)
					report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
				if (rsp.read_value !== want.read_value)
					report_mismatch("read_value", rsp.read_value, want.read_value);
				if (rsp.entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(rsp.entry_count),
						32'(want.entry_count));
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !watchdog_on) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == 3'(chm_pkg::REG_KEY_MODE) * 4) mode_q = data[0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// send one item at a falling edge, hold until accepted; valid stays up
	// for a following item and is dropped by an idle cycle or by drain
	task automatic send_item(input chm_pkg::req_t r, input bit fixed,
			input chm_pkg::rsp_t e);
		chm_pkg::rsp_t p;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		p = map_apply(r);
		if (fixed && p !== e)
			report_mismatch("directed row vs shadow", 32'(p), 32'(e));
		pending_rsp.push_back(p);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic chm_pkg::req_t mk(input logic [2:0] c, input logic [31:0] k,
			input logic [31:0] v);
		chm_pkg::req_t r;
		r.cmd = c; r.key = k; r.value = v;
		return r;
	endfunction

	function automatic chm_pkg::rsp_t ex(input logic [1:0] s, input logic h,
			input logic [31:0] v, input logic [8:0] n);
		chm_pkg::rsp_t o;
		o.status = s; o.hit = h; o.read_value = v; o.entry_count = n;
		return o;
	endfunction

	function automatic logic [31:0] pick_key(input int span);
		if (live_keys.size() > 0 && $urandom_range(99) < 60)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		if (span > 0) return 32'($urandom_range(span));
		return $urandom();
	endfunction

	// random phase of n items; key span steers chain depth and pool fill
	task automatic random_phase(input int n, input int span, input int fill_bias);
		chm_pkg::req_t r;
		chm_pkg::rsp_t z;
		int            roll;
		z = '0;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			r.key = pick_key(span);
			r.value = $urandom();
			if (roll < 2) r.cmd = chm_pkg::CMD_CLEAR;
			else if (roll < 4) r.cmd = 3'($urandom_range(7, 5));
			else if (roll < 4 + fill_bias)
				r.cmd = ($urandom_range(1)) ? chm_pkg::CMD_ADD : chm_pkg::CMD_SET;
			else if (roll < 70) r.cmd = chm_pkg::CMD_GET;
			else r.cmd = chm_pkg::CMD_REMOVE;
			if (r.cmd == chm_pkg::CMD_ADD || r.cmd == chm_pkg::CMD_SET)
				live_keys.push_back(r.key);
			if (r.cmd == chm_pkg::CMD_CLEAR) live_keys.delete();
			if (live_keys.size() > 400) live_keys.delete(0);
			send_item(r, 1'b0, z);
		end
	endtask

	initial begin
		row_t          rows [$];
		chm_pkg::rsp_t z;
		int            per;
		z = '0;
		errors = 0; sent = 0; idle_cycles = 0; watchdog_on = 1'b0;
		send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0; req = '0; rsp_stall = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mode_q = 1'b0;
		for (int i = 0; i < chm_pkg::ENTRIES; i++) begin
			key_q[i] = '0; val_q[i] = '0; prev_q[i] = chm_pkg::NIL_IDX;
		end
		map_empty();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		watchdog_on = 1'b1;
		@(negedge clk);

		// directed: extremes, every command, misses, hits, unused codes, clear
		rows.push_back('{mk(chm_pkg::CMD_GET, 32'h0, 32'h0), 1,
			ex(chm_pkg::ST_MISS, 0, 0, 0)});
		rows.push_back('{mk(chm_pkg::CMD_REMOVE, 32'hffffffff, 0), 1,
			ex(chm_pkg::ST_MISS, 0, 0, 0)});
		rows.push_back('{mk(chm_pkg::CMD_ADD, 32'h0, 32'hffffffff), 1,
			ex(chm_pkg::ST_DONE, 0, 0, 1)});
		rows.push_back('{mk(chm_pkg::CMD_ADD, 32'hffffffff, 32'h0), 1,
			ex(chm_pkg::ST_DONE, 0, 0, 2)});
		rows.push_back('{mk(chm_pkg::CMD_GET, 32'h0, 0), 1,
			ex(chm_pkg::ST_DONE, 1, 32'hffffffff, 2)});
		rows.push_back('{mk(chm_pkg::CMD_ADD, 32'h0, 32'h5), 1,
			ex(chm_pkg::ST_MISS, 1, 0, 2)});
		rows.push_back('{mk(chm_pkg::CMD_SET, 32'h0, 32'h5a5a5a5a), 1,
			ex(chm_pkg::ST_DONE, 1, 0, 2)});
		rows.push_back('{mk(chm_pkg::CMD_GET, 32'h0, 0), 1,
			ex(chm_pkg::ST_DONE, 1, 32'h5a5a5a5a, 2)});
		rows.push_back('{mk(chm_pkg::CMD_SET, 32'h80000000, 32'ha5a5a5a5), 1,
			ex(chm_pkg::ST_DONE, 0, 0, 3)});
		rows.push_back('{mk(3'd5, 32'h0, 0), 1, ex(chm_pkg::ST_DONE, 0, 0, 3)});
		rows.push_back('{mk(3'd7, 32'hffffffff, 32'hffffffff), 1,
			ex(chm_pkg::ST_DONE, 0, 0, 3)});
		// add three keys and remove them again; in key mode 0 they fall in separate buckets
		rows.push_back('{mk(chm_pkg::CMD_ADD, 32'h40, 32'h11), 0, z});
		rows.push_back('{mk(chm_pkg::CMD_ADD, 32'h80, 32'h22), 0, z});
		rows.push_back('{mk(chm_pkg::CMD_ADD, 32'hc0, 32'h33), 0, z});
		rows.push_back('{mk(chm_pkg::CMD_REMOVE, 32'h80, 0), 0, z});
		rows.push_back('{mk(chm_pkg::CMD_GET, 32'h40, 0), 0, z});
		rows.push_back('{mk(chm_pkg::CMD_REMOVE, 32'hc0, 0), 0, z});
		rows.push_back('{mk(chm_pkg::CMD_REMOVE, 32'h40, 0), 0, z});
		rows.push_back('{mk(chm_pkg::CMD_REMOVE, 32'hffffffff, 0), 1,
			ex(chm_pkg::ST_DONE, 1, 0, 2)});
		rows.push_back('{mk(chm_pkg::CMD_GET, 32'hffffffff, 0), 1,
			ex(chm_pkg::ST_MISS, 0, 0, 2)});
		rows.push_back('{mk(chm_pkg::CMD_CLEAR, 32'h1234, 32'h5678), 1,
			ex(chm_pkg::ST_DONE, 0, 0, 0)});
		rows.push_back('{mk(chm_pkg::CMD_GET, 32'h0, 0), 1,
			ex(chm_pkg::ST_MISS, 0, 0, 0)});
		foreach (rows[i]) send_item(rows[i].r, rows[i].fixed, rows[i].e);

		// full pool: fill with 256 distinct keys, then add/set an absent key, set a present one and clear
		drain();
		reg_write(3'd0, 32'd1);
		for (int i = 0; i < chm_pkg::ENTRIES; i++)
			send_item(mk(chm_pkg::CMD_ADD, 32'(i * 3), 32'(i)), 0, z);
		send_item(mk(chm_pkg::CMD_ADD, 32'hdeadbeef, 1), 1,
			ex(chm_pkg::ST_FULL, 0, 0, 256));
		send_item(mk(chm_pkg::CMD_SET, 32'hdeadbeef, 1), 1,
			ex(chm_pkg::ST_FULL, 0, 0, 256));
		send_item(mk(chm_pkg::CMD_SET, 32'd3, 32'h77), 1,
			ex(chm_pkg::ST_DONE, 1, 0, 256));
		send_item(mk(chm_pkg::CMD_CLEAR, 0, 0), 1, ex(chm_pkg::ST_DONE, 0, 0, 0));
		live_keys.delete();

		// random phases across idle/stall mixes and both key modes
		per = N_RANDOM / 5;
		drain();
		reg_write(3'd0, 32'd0);
		random_phase(per, 255, 40);
		send_idle_pct = 72;
		random_phase(per, 0, 40);
		drain();
		reg_write(3'd0, 32'd1);
		// write outside the register set is ignored
		reg_write(3'd4, 32'd0);
		send_idle_pct = 0; recv_stall_pct = 72;
		random_phase(per, 4095, 55);
		send_idle_pct = 35; recv_stall_pct = 35;
		random_phase(per, 1023, 50);
		drain();
		reg_write(3'd0, 32'd0);
		send_idle_pct = 0; recv_stall_pct = 0;
		random_phase(per, 0, 35);

		drain();
		watchdog_on = 1'b0;
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> chained_hash_map_engine.f
hw/rtl/chm_pkg.sv
hw/rtl/chm_ctrl.sv
hw/rtl/chm_dp.sv
hw/rtl/chained_hash_map_engine.sv
tb/tb.sv
